// ----- src/ptd_pkg.sv -----
// Package for the point transform core: formats, status codes, helpers.
package ptd_pkg;

    localparam int DefaultFracBits = 16;
    localparam int NumRegs         = 8;
    localparam int RegIdxW         = 3;
    localparam int CfgDataW        = 64;
    localparam int SumW            = 66;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_WZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic       dir;
        logic       sat;
    } ptd_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
        if (v > 66'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic is_sat32(input logic signed [SumW-1:0] v);
        is_sat32 = (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

endpackage

// ----- src/ptd_mac.sv -----
// Matrix stage: four rows of three products, summed and saturated.
module ptd_mac import ptd_pkg::*; #(
    parameter int FRAC_BITS = DefaultFracBits
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      in_dir,
    input  logic signed [31:0]        in_x,
    input  logic signed [31:0]        in_y,
    input  logic signed [31:0]        in_z,
    input  logic [16*32-1:0]          mat,
    output logic                      out_valid,
    output ptd_ctl_t                  out_ctl,
    output logic signed [31:0]        out_r [4]
);

    logic                     v1_reg, v2_reg;
    logic                     d1_reg, d2_reg;
    logic signed [63:0]       p_reg [4][3];
    logic signed [31:0]       t_reg [4];
    logic signed [31:0]       r_reg [4];
    logic                     s_reg;
    logic signed [31:0]       vin [3];
    logic signed [SumW-1:0]   sum [4];
    logic                     sat_any;
    logic                     v1_next;

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;
    assign v1_next = in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg <= in_dir;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    p_reg[r][c] <= $signed(mat[(4*c+r)*32 +: 32]) * vin[c];
                end
                t_reg[r] <= in_dir ? 32'sd0 : $signed(mat[(12+r)*32 +: 32]);
            end
        end
    end

    always_comb begin
        sat_any = 1'b0;
        for (int r = 0; r < 4; r++) begin
            sum[r] = SumW'(p_reg[r][0] >>> FRAC_BITS) + SumW'(p_reg[r][1] >>> FRAC_BITS)
                   + SumW'(p_reg[r][2] >>> FRAC_BITS) + SumW'(t_reg[r]);
            if (is_sat32(sum[r]) && (r < 3 || !d1_reg)) begin
                sat_any = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg <= d1_reg;
            s_reg  <= sat_any;
            for (int r = 0; r < 4; r++) begin
                r_reg[r] <= sat32(sum[r]);
            end
        end
    end

    assign out_valid   = v2_reg;
    assign out_ctl.dir = d2_reg;
    assign out_ctl.sat = s_reg;
    assign out_r       = r_reg;

endmodule

// ----- src/ptd_div.sv -----
// Pipelined restoring divider for the three components by w.
module ptd_div import ptd_pkg::*; #(
    parameter int FRAC_BITS = DefaultFracBits
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  ptd_ctl_t                  in_ctl,
    input  logic signed [31:0]        in_r [4],
    output logic                      out_valid,
    output logic signed [31:0]        out_x,
    output logic signed [31:0]        out_y,
    output logic signed [31:0]        out_z,
    output logic [1:0]                out_status
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int DivStages = NW;
    localparam logic signed [NW+1:0] QMax = (NW+2)'(64'sd2147483647);
    localparam logic signed [NW+1:0] QMin = (NW+2)'(-64'sd2147483648);

    logic              v_reg   [DivStages+1];
    ptd_ctl_t          c_reg   [DivStages+1];
    logic              wz_reg  [DivStages+1];
    logic [31:0]       raw_reg [DivStages+1][3];
    logic [NW-1:0]     q_reg   [DivStages+1][3];
    logic [32:0]       rem_reg [DivStages+1][3];
    logic [31:0]       dv_reg  [DivStages+1];
    logic              neg_reg [DivStages+1][3];
    logic [NW-1:0]     num     [3];
    logic [32:0]       rsh     [DivStages][3];
    logic [NW:0]       qs      [3];
    logic signed [NW+1:0] qv   [3];
    logic signed [31:0] res    [3];
    logic              qsat    [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [31:0] a;
            a = in_r[k][31] ? 32'(-in_r[k]) : in_r[k];
            num[k] = NW'({a, {FRAC_BITS{1'b0}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= DivStages; s++) v_reg[s] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= DivStages; s++) v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[0]  <= in_ctl;
            wz_reg[0] <= (in_r[3] == 32'sd0);
            dv_reg[0] <= in_r[3][31] ? 32'(-in_r[3]) : in_r[3];
            for (int k = 0; k < 3; k++) begin
                raw_reg[0][k] <= in_r[k];
                q_reg[0][k]   <= num[k];
                rem_reg[0][k] <= 33'd0;
                neg_reg[0][k] <= in_r[k][31] ^ in_r[3][31];
            end
            for (int s = 1; s <= DivStages; s++) begin
                c_reg[s]  <= c_reg[s-1];
                wz_reg[s] <= wz_reg[s-1];
                dv_reg[s] <= dv_reg[s-1];
                for (int k = 0; k < 3; k++) begin
                    raw_reg[s][k] <= raw_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                    if (s <= NW) begin
                        if (rsh[s-1][k] >= {1'b0, dv_reg[s-1]}) begin
                            rem_reg[s][k] <= rsh[s-1][k] - {1'b0, dv_reg[s-1]};
                            q_reg[s][k]   <= {q_reg[s-1][k][NW-2:0], 1'b1};
                        end else begin
                            rem_reg[s][k] <= rsh[s-1][k];
                            q_reg[s][k]   <= {q_reg[s-1][k][NW-2:0], 1'b0};
                        end
                    end else begin
                        rem_reg[s][k] <= rem_reg[s-1][k];
                        q_reg[s][k]   <= q_reg[s-1][k];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int s = 0; s < DivStages; s++) begin
            for (int k = 0; k < 3; k++) begin
                rsh[s][k] = {rem_reg[s][k][31:0], q_reg[s][k][NW-1]};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qs[k] = {1'b0, q_reg[DivStages][k]};
            qv[k] = neg_reg[DivStages][k] ? -$signed({1'b0, qs[k]}) : $signed({1'b0, qs[k]});
            qsat[k] = (qv[k] > QMax) || (qv[k] < QMin);
            res[k] = qsat[k] ? (qv[k][NW+1] ? 32'sh80000000 : 32'sh7fffffff) : qv[k][31:0];
        end
    end

    always_comb begin
        if (c_reg[DivStages].dir) begin
            out_x = raw_reg[DivStages][0];
            out_y = raw_reg[DivStages][1];
            out_z = raw_reg[DivStages][2];
            out_status = c_reg[DivStages].sat ? STATUS_SAT : STATUS_OK;
        end else if (wz_reg[DivStages]) begin
            out_x = '0;
            out_y = '0;
            out_z = '0;
            out_status = STATUS_WZERO;
        end else begin
            out_x = res[0];
            out_y = res[1];
            out_z = res[2];
            out_status = (c_reg[DivStages].sat || qsat[0] || qsat[1] || qsat[2])
                       ? STATUS_SAT : STATUS_OK;
        end
    end

    assign out_valid = v_reg[DivStages];

endmodule

// ----- src/point_transform_with_divide_core.sv -----
// Top level: matrix registers, pipeline, output register.
//
// Input transactions on s_valid/s_ready carry opcode and a Q16.16 vector.
// Result transactions on m_valid/m_ready carry out_x/y/z and status.
// The matrix is written through cfg_we/cfg_idx/cfg_data; the user must
// write it only while idle; the block itself does not enforce this.
// Each transaction passes through 2 stages of multiply and sum, 1 divider
// load stage, 32 + FRAC_BITS quotient stages (48 at Q16.16, one quotient
// bit a stage) and the output register, one transaction per cycle unless stalled.
// The whole pipeline advances only when the output register is free or
// being taken, so a stall of m_ready holds every stage and loses nothing.
// Reset (aresetn low, synchronous) loads the identity matrix and empties
// the pipeline.
// Status: 0 ok, 1 w was zero, 2 a value saturated.
//
module point_transform_with_divide_core import ptd_pkg::*; #(
    parameter int FRAC_BITS = DefaultFracBits
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [RegIdxW-1:0]   cfg_idx,
    input  logic [CfgDataW-1:0]  cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic signed [31:0]   s_in_x,
    input  logic signed [31:0]   s_in_y,
    input  logic signed [31:0]   s_in_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_out_x,
    output logic signed [31:0]   m_out_y,
    output logic signed [31:0]   m_out_z,
    output logic [1:0]           m_status
);

    localparam logic [31:0] One = 32'(1) << FRAC_BITS;

    logic [CfgDataW-1:0]  mat_reg [NumRegs];
    logic [16*32-1:0]     mat;
    logic                 en;
    logic                 mac_valid;
    ptd_ctl_t             mac_ctl;
    logic signed [31:0]   mac_r [4];
    logic                 div_valid;
    logic signed [31:0]   dx, dy, dz;
    logic [1:0]           dst;
    logic                 ov_reg;
    logic signed [31:0]   ox_reg, oy_reg, oz_reg;
    logic [1:0]           os_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumRegs; i++) begin
                mat_reg[i] <= (i == 0 || i == 5) ? {32'd0, One}
                            : (i == 2 || i == 7) ? {One, 32'd0} : '0;
            end
        end else if (cfg_we) begin
            mat_reg[cfg_idx] <= cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < NumRegs; i++) mat[i*64 +: 64] = mat_reg[i];
    end

    assign en      = !ov_reg || m_ready;
    assign s_ready = en;

    ptd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_dir(s_opcode),
        .in_x(s_in_x), .in_y(s_in_y), .in_z(s_in_z), .mat(mat),
        .out_valid(mac_valid), .out_ctl(mac_ctl), .out_r(mac_r)
    );

    ptd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(mac_valid), .in_ctl(mac_ctl), .in_r(mac_r),
        .out_valid(div_valid), .out_x(dx), .out_y(dy), .out_z(dz),
        .out_status(dst)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg <= dx;
            oy_reg <= dy;
            oz_reg <= dz;
            os_reg <= dst;
        end
    end

    assign m_valid  = ov_reg;
    assign m_out_x  = ox_reg;
    assign m_out_y  = oy_reg;
    assign m_out_z  = oz_reg;
    assign m_status = os_reg;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3) else $error("bad status");
    a_wzero_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_WZERO) |->
        (m_out_x == 0 && m_out_y == 0 && m_out_z == 0)) else $error("w zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_x) && $stable(m_status)))
        else $error("hold");

endmodule
